>>> hdl/next_fit_page_allocator_top_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef NEXT_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NFPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define NFPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/nfpa_pkg.sv
// Shared widths, codes and types of the next-fit page allocator.
package nfpa_pkg;

	localparam int NUM_PAGES_DEFAULT = 1024;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CNT_W     = 11;
	localparam int ALIGN_W   = 11;
	localparam int FPAGE_W   = 10;
	localparam int OPAGE_W   = 10;
	localparam int STATUS_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FIRST = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 1'd1;

	localparam logic [CFG_W-1:0] CFG_FIRST_RESET = 11'd0;
	localparam logic [CFG_W-1:0] CFG_END_RESET   = 11'd1024;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ZERO_COUNT = 2'd1,
		STATUS_NO_FIT     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               start;
		logic [ALIGN_W-1:0] divisor;
	} nfpa_mod_req_t;

	typedef struct packed {
		logic               done;
		logic [ALIGN_W-1:0] rem;
	} nfpa_mod_rsp_t;

endpackage

>>> hdl/nfpa_in_if.sv
// Request channel: command beat with page count, alignment and free start.
interface nfpa_in_if import nfpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [CNT_W-1:0]   page_count;
	logic [ALIGN_W-1:0] align_pages;
	logic [FPAGE_W-1:0] free_start_page;

	modport source (output valid, cmd, page_count, align_pages, free_start_page, input ready);
	modport sink   (input valid, cmd, page_count, align_pages, free_start_page, output ready);
endinterface

>>> hdl/nfpa_out_if.sv
// Response channel: status and first page of the allocation.
interface nfpa_out_if import nfpa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OPAGE_W-1:0]  alloc_start_page;

	modport source (output valid, status, alloc_start_page, input ready);
	modport sink   (input valid, status, alloc_start_page, output ready);
endinterface

>>> hdl/nfpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nfpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/nfpa_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module nfpa_mod import nfpa_pkg::*; #(
	parameter int DW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  nfpa_mod_req_t req,
	input  logic [DW-1:0] dividend,
	output nfpa_mod_rsp_t rsp
);

	localparam int CW = $clog2(DW);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [DW-1:0]      dvd_q;
	logic [ALIGN_W:0]   rem_q;
	logic [ALIGN_W-1:0] div_q;

	logic [ALIGN_W:0] shifted;
	logic [ALIGN_W:0] rem_n;

	always_comb begin
		shifted = {rem_q[ALIGN_W-1:0], dvd_q[DW-1]};
		rem_n   = (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			dvd_q <= dividend;
			div_q <= req.divisor;
			rem_q <= '0;
			cnt_q <= CW'(DW - 1);
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// remainder is below the divisor, so the top bit is always clear
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[ALIGN_W-1:0];

endmodule

>>> hdl/next_fit_page_allocator_top.sv
// Top level of the next-fit page allocator with guard pages.
//
//  channel    dir  modport  beat carries
//  req        in   sink     cmd, page_count, align_pages, free_start_page
//  rsp        out  source   status, alloc_start_page
//  cfg_*      in   -        window_first_page (0), window_end_page (1)
//
// After reset a clearing pass writes every map entry before req is ready.
// Free: one map write a cycle for the pages of the range that lie inside the map.
// Alloc: the two alignment remainders are computed, then the window is scanned (one map read
// a cycle on the single read port), then page_count map entries are marked.
// One request is worked on at a time; a finished response waits in the output
// register and the next request is taken meanwhile.
`include "next_fit_page_allocator_top_macros.svh"

module next_fit_page_allocator_top import nfpa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	nfpa_in_if.sink              req,
	nfpa_out_if.source           rsp
);

	localparam int NW = ($clog2(NUM_PAGES + 1) > CFG_W) ? $clog2(NUM_PAGES + 1) : CFG_W;
	localparam int PW = $clog2(NUM_PAGES);
	localparam int DW = NW + 1;
	localparam int RW = CNT_W + 1;

	state_t state_q, state_n;

	logic [CFG_W-1:0] cfg_first_q, cfg_end_q;
	logic [CFG_W-1:0] ptr_q;

	logic [NW-1:0] first_c, end_c, span_c;

	logic [ALIGN_W-1:0] align_q, align_in;
	logic [RW-1:0]      need_q;
	logic [CNT_W-1:0]   left_q;
	logic [NW:0]        wa_q;

	logic [NW-1:0]      p_q, iss_q, ev_q, rstart_q;
	logic [ALIGN_W-1:0] rem_q, remf_q;
	logic [RW-1:0]      run_q;

	logic [NW-1:0]      addr_s1;
	logic [ALIGN_W-1:0] rem_s1;
	logic               wrap_s1, vld_s1;

	status_t            res_status_q, out_status_q;
	logic [OPAGE_W-1:0] res_page_q, out_page_q;
	logic               out_valid_q;

	logic accept, go_alloc, issue, out_win, found, last, load_out;
	logic [NW-1:0]      a_c;
	logic [ALIGN_W-1:0] ra_c, ra_inc, rem_adv;
	logic [RW-1:0]      run_base, run_e;
	logic [NW-1:0]      start_e;

	logic          ram_we;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [0:0]    ram_wdata, ram_rdata;

	nfpa_mod_req_t mreq;
	nfpa_mod_rsp_t mrsp_p, mrsp_f;
	logic [DW-1:0] dvd_p, dvd_f;

	// window bounds clamped to the map
	always_comb begin
		first_c = (NW'(cfg_first_q) > NW'(NUM_PAGES)) ? NW'(NUM_PAGES) : NW'(cfg_first_q);
		end_c   = (NW'(cfg_end_q) > NW'(NUM_PAGES)) ? NW'(NUM_PAGES) : NW'(cfg_end_q);
		span_c  = (end_c > first_c) ? end_c - first_c : '0;
	end

	always_comb begin
		accept   = req.valid && req.ready;
		align_in = (req.align_pages == '0) ? ALIGN_W'(1) : req.align_pages;
		go_alloc = accept && req.page_count != '0 && req.cmd == CMD_ALLOC && span_c != '0;
	end

	// remainders of (pointer + 1) and (first + 1) by the alignment
	always_comb begin
		mreq.start   = go_alloc;
		mreq.divisor = align_in;
		dvd_p        = DW'(ptr_q) + DW'(1);
		dvd_f        = DW'(first_c) + DW'(1);
	end

	nfpa_mod #(.DW(DW)) u_mod_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.dividend (dvd_p),
		.rsp      (mrsp_p)
	);

	nfpa_mod #(.DW(DW)) u_mod_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.dividend (dvd_f),
		.rsp      (mrsp_f)
	);

	// issue side of the scan: address sequence does not depend on map data
	always_comb begin
		issue   = (state_q == ST_SCAN) && (iss_q != span_c);
		out_win = (p_q >= end_c) || (p_q < first_c);
		a_c     = out_win ? first_c : p_q;
		ra_c    = out_win ? remf_q : rem_q;
		ra_inc  = ra_c + ALIGN_W'(1);
		rem_adv = (ra_inc == align_q) ? '0 : ra_inc;
	end

	// evaluate side: map bit of the address issued last cycle
	always_comb begin
		run_base = wrap_s1 ? '0 : run_q;
		start_e  = rstart_q;
		priority if (ram_rdata[0]) begin
			run_e = '0;
		end else if (run_base == '0) begin
			if (rem_s1 == '0) begin
				run_e   = RW'(1);
				start_e = addr_s1;
			end else begin
				run_e = '0;
			end
		end else begin
			run_e = run_base + RW'(1);
		end
		found = (state_q == ST_SCAN) && vld_s1 && (run_e >= need_q);
		last  = (state_q == ST_SCAN) && vld_s1 && (ev_q + NW'(1) == span_c);
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (wa_q == (NW + 1)'(NUM_PAGES - 1)) state_n = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					priority if (req.page_count == '0) state_n = ST_DONE;
					else if (req.cmd == CMD_FREE)    state_n = ST_FREE;
					else if (span_c == '0)           state_n = ST_DONE;
					else                             state_n = ST_MOD;
				end
			end
			ST_MOD:  if (mrsp_p.done) state_n = ST_SCAN;
			ST_SCAN: begin
				priority if (found) state_n = ST_MARK;
				else if (last)      state_n = ST_DONE;
			end
			ST_MARK: if (left_q == CNT_W'(1)) state_n = ST_DONE;
			ST_FREE: if (left_q == CNT_W'(1)) state_n = ST_DONE;
			ST_DONE: if (!out_valid_q || rsp.ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		load_out  = 1'b0;
		ram_waddr = wa_q[PW-1:0];
		ram_raddr = a_c[PW-1:0];
		unique case (state_q)
			ST_CLEAR: ram_we = 1'b1;
			ST_IDLE:  req.ready = 1'b1;
			ST_MARK: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
			end
			ST_FREE:  ram_we = (wa_q < (NW + 1)'(NUM_PAGES));
			ST_DONE:  load_out = !out_valid_q || rsp.ready;
			ST_MOD, ST_SCAN: ;
			default: ;
		endcase
	end

	nfpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cfg_first_q <= CFG_FIRST_RESET;
			cfg_end_q   <= CFG_END_RESET;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			wa_q        <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_FIRST: cfg_first_q <= cfg_wdata;
					REG_WINDOW_END:   cfg_end_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (found) begin
				ptr_q <= CFG_W'(addr_s1 + NW'(1));
			end else if (last) begin
				ptr_q <= p_q[CFG_W-1:0];
			end
			vld_s1 <= issue;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			priority if (state_q == ST_CLEAR || state_q == ST_MARK || state_q == ST_FREE) begin
				wa_q <= wa_q + (NW + 1)'(1);
			end else if (accept) begin
				wa_q <= (NW + 1)'(req.free_start_page);
			end else if (found) begin
				wa_q <= (NW + 1)'(start_e) + (NW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			align_q      <= align_in;
			need_q       <= RW'(req.page_count) + RW'(2);
			left_q       <= req.page_count;
			res_page_q   <= '0;
			priority if (req.page_count == '0) res_status_q <= STATUS_ZERO_COUNT;
			else if (req.cmd == CMD_FREE)    res_status_q <= STATUS_OK;
			else                             res_status_q <= STATUS_NO_FIT;
		end
		if (state_q == ST_MARK || state_q == ST_FREE) begin
			left_q <= left_q - CNT_W'(1);
		end
		if (state_q == ST_MOD && mrsp_p.done) begin
			p_q    <= NW'(ptr_q);
			rem_q  <= mrsp_p.rem;
			remf_q <= mrsp_f.rem;
			iss_q  <= '0;
			ev_q   <= '0;
			run_q  <= '0;
		end
		if (issue) begin
			p_q     <= a_c + NW'(1);
			rem_q   <= rem_adv;
			iss_q   <= iss_q + NW'(1);
			addr_s1 <= a_c;
			rem_s1  <= ra_c;
			wrap_s1 <= out_win;
		end
		if (state_q == ST_SCAN && vld_s1) begin
			run_q    <= run_e;
			rstart_q <= start_e;
			ev_q     <= ev_q + NW'(1);
		end
		if (found) begin
			res_status_q <= STATUS_OK;
			res_page_q   <= OPAGE_W'(start_e + NW'(1));
		end else if (last) begin
			res_status_q <= STATUS_NO_FIT;
			res_page_q   <= '0;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_page_q   <= res_page_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.alloc_start_page = out_page_q;

	`NFPA_ASSERT_IMP(a_scan_no_write, clk, arst_n, state_q == ST_SCAN, !ram_we, "map written during scan")
	`NFPA_ASSERT_IMP(a_scan_order, clk, arst_n, state_q == ST_SCAN, (ev_q <= iss_q) && (iss_q <= span_c), "scan counters out of order")
	`NFPA_ASSERT_IMP(a_mark_in_window, clk, arst_n, state_q == ST_MARK, (wa_q < (NW + 1)'(end_c)) && (wa_q > (NW + 1)'(first_c)), "marking outside window")
	`NFPA_ASSERT_IMP(a_mod_done, clk, arst_n, mrsp_p.done, (state_q == ST_MOD) && mrsp_f.done, "remainder units out of step")

endmodule
